/* hw/rtl/irce_pkg.sv */
// Package: shared constants, types and the pulse word table for the IR carrier run encoder.
package irce_pkg;

  // Field widths
  localparam int DUR_W      = 20;
  localparam int CARRIER_W  = 19;
  localparam int DUTY_W     = 7;
  localparam int WORD_W     = 16;
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W  = 2;

  // Frame buffer size in shift words
  localparam int BUFFER_WORDS = 8192;
  localparam int COUNT_W      = $clog2(BUFFER_WORDS);

  // Period arithmetic: periods = (dur * carrier + 500000) / 1000000
  localparam int PROD_W  = DUR_W + CARRIER_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(500000);
  localparam logic [SUM_W-1:0] SUM_CAP   = SUM_W'(64'(BUFFER_WORDS) * 64'd1000000);

  // 1000000 = 64 * 15625: shift out 64, then multiply by a reciprocal of 15625
  localparam int DIV_SHIFT   = 6;
  localparam int Q1_W        = $clog2(64'(BUFFER_WORDS) * 64'd1000000) - DIV_SHIFT;
  localparam int RECIP_W     = Q1_W + 1;
  localparam int RECIP_SHIFT = Q1_W + 14;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd15624)
                                                  / 64'd15625);
  localparam int RPROD_W = Q1_W + RECIP_W;

  // Pulse words by duty cycle
  localparam logic [WORD_W-1:0] WORD_DUTY_90 = 16'h8000;
  localparam logic [WORD_W-1:0] WORD_DUTY_80 = 16'hc000;
  localparam logic [WORD_W-1:0] WORD_DUTY_75 = 16'hf000;
  localparam logic [WORD_W-1:0] WORD_DUTY_70 = 16'hf800;
  localparam logic [WORD_W-1:0] WORD_DUTY_60 = 16'hfc00;
  localparam logic [WORD_W-1:0] WORD_DUTY_50 = 16'hff00;
  localparam logic [WORD_W-1:0] WORD_SPACE_HI = 16'hffff;
  localparam logic [WORD_W-1:0] WORD_SPACE_LO = 16'h0000;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_HZ   = 2'd0,
    CFG_DUTY_PERCENT = 2'd1,
    CFG_ACTIVE_LOW   = 2'd2
  } cfg_idx_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0]  pattern_word;
    logic [COUNT_W-1:0] periods;
    logic               big;
    logic               is_space;
    logic               frame_start;
  } item_t;

  // Pulse word for a duty request, inverted for an active-low LED
  function automatic logic [WORD_W-1:0] pulse_word(input logic [DUTY_W-1:0] duty,
                                                   input logic active_low);
    logic [WORD_W-1:0] w;
    begin
      case (duty) inside
        [7'd90:7'd127]: w = WORD_DUTY_90;
        [7'd80:7'd89]:  w = WORD_DUTY_80;
        [7'd75:7'd79]:  w = WORD_DUTY_75;
        [7'd70:7'd74]:  w = WORD_DUTY_70;
        [7'd60:7'd69]:  w = WORD_DUTY_60;
        default:        w = WORD_DUTY_50;
      endcase
      pulse_word = active_low ? ~w : w;
    end
  endfunction

endpackage

/* hw/rtl/irce_front.sv */
// Front: accepts requests, tracks pulse/space order and computes the period count.
module irce_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [irce_pkg::DUR_W-1:0]        in_duration_us,
  input  logic                              in_frame_start,
  input  logic [irce_pkg::CARRIER_W-1:0]    carrier_hz,
  input  logic [irce_pkg::DUTY_W-1:0]       duty_percent,
  input  logic                              active_low,
  output logic                              q_push,
  output irce_pkg::item_t                   q_item,
  input  logic                              q_full
);
  import irce_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0]   s1_prod_r;
  logic [WORD_W-1:0]   s1_word_r;
  logic                s1_space_r;
  logic                s1_start_r;
  logic                s2_valid_r, s2_valid_nxt;
  logic [RPROD_W-1:0]  s2_rprod_r;
  logic                s2_big_r;
  logic [WORD_W-1:0]   s2_word_r;
  logic                s2_space_r;
  logic                s2_start_r;
  logic                next_space_r, next_space_nxt;
  logic                s1_ready, s2_ready, accept;
  logic                cur_space;
  logic [WORD_W-1:0]   cur_word;
  logic [SUM_W-1:0]    s2_sum;
  logic [Q1_W-1:0]     s2_q1;

  // Stage handshakes
  assign s2_ready = !s2_valid_r || !q_full;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign accept   = in_valid && s1_ready;
  assign in_stall = !s1_ready;
  assign q_push   = s2_valid_r && !q_full;

  // Classify the request as pulse or space and pick its word
  always_comb begin
    cur_space      = in_frame_start ? 1'b0 : next_space_r;
    next_space_nxt = accept ? !cur_space : next_space_r;
    if (cur_space) begin
      cur_word = active_low ? WORD_SPACE_HI : WORD_SPACE_LO;
    end else begin
      cur_word = pulse_word(duty_percent, active_low);
    end
  end

  // Round and shift out the factor 64; stage 2 flags counts at or past the buffer size from this sum
  always_comb begin
    s2_sum = {1'b0, s1_prod_r} + ROUND_ADD;
    s2_q1  = s2_sum[DIV_SHIFT +: Q1_W];
  end

  always_comb begin
    s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      next_space_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      next_space_r <= next_space_nxt;
    end
  end

  // Stage 1: duration times carrier
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r  <= PROD_W'(in_duration_us) * PROD_W'(carrier_hz);
      s1_word_r  <= cur_word;
      s1_space_r <= cur_space;
      s1_start_r <= in_frame_start;
    end
  end

  // Stage 2: reciprocal multiply for the divide by 15625
  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_rprod_r <= RPROD_W'(s2_q1) * RPROD_W'(RECIP);
      s2_big_r   <= (s2_sum >= SUM_CAP);
      s2_word_r  <= s1_word_r;
      s2_space_r <= s1_space_r;
      s2_start_r <= s1_start_r;
    end
  end

  // Hand the classified request to the queue
  always_comb begin
    q_item.pattern_word = s2_word_r;
    q_item.periods      = s2_rprod_r[RECIP_SHIFT +: COUNT_W];
    q_item.big          = s2_big_r;
    q_item.is_space     = s2_space_r;
    q_item.frame_start  = s2_start_r;
  end

endmodule

/* hw/rtl/irce_queue.sv */
// Queue: short FIFO of classified requests between the front and the back.
module irce_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  irce_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output irce_pkg::item_t  head_item,
  output logic             empty
);
  import irce_pkg::*;

  item_t               slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slots_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/irce_back.sv */
// Back: frame word accounting, sticky overflow and the output register.
module irce_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  irce_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irce_pkg::WORD_W-1:0]    out_pattern_word,
  output logic [irce_pkg::COUNT_W-1:0]   out_repeat_count,
  output logic                           out_is_space,
  output logic                           out_overflow
);
  import irce_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    word_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 space_r;
  logic                 ovf_out_r;
  logic [COUNT_W-1:0]   words_used_r, words_used_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [COUNT_W-1:0]   base;
  logic                 base_ovf;
  logic [COUNT_W:0]     sum;

  // Pop when the output register is free or being taken
  assign q_pop         = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Account for the popped request
  always_comb begin
    base           = q_item.frame_start ? '0 : words_used_r;
    base_ovf       = q_item.frame_start ? 1'b0 : ovf_r;
    sum            = {1'b0, base} + {1'b0, q_item.periods};
    words_used_nxt = words_used_r;
    ovf_nxt        = ovf_r;
    count_nxt      = '0;
    if (q_pop) begin
      words_used_nxt = base;
      ovf_nxt        = base_ovf;
      if (!base_ovf) begin
        if (q_item.big || sum >= (COUNT_W + 1)'(BUFFER_WORDS)) begin
          ovf_nxt = 1'b1;
        end else begin
          words_used_nxt = sum[COUNT_W-1:0];
          count_nxt      = q_item.periods;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      words_used_r <= '0;
      ovf_r        <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      words_used_r <= words_used_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r    <= q_item.pattern_word;
      count_r   <= count_nxt;
      space_r   <= q_item.is_space;
      ovf_out_r <= ovf_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pattern_word = word_r;
  assign out_repeat_count = count_r;
  assign out_is_space     = space_r;
  assign out_overflow     = ovf_out_r;

endmodule

/* hw/rtl/ir_carrier_run_encoder.sv */
// Top level: configuration registers and the front, queue and back of the run encoder.
// Takes one pulse or space duration per cycle while in_stall is low and gives one run
// descriptor per request, in order; each result passes through the two multiplier
// stages of the front (duration times carrier, then a reciprocal multiply for the
// divide by one million), a four-entry queue and the output register. Stalls on the
// output fill the queue first and reach in_stall only once it and the front stages
// are full. Configuration is to be written while no request is in flight; the block
// itself does not enforce this. A carrier write of zero is ignored.
module ir_carrier_run_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [irce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irce_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [irce_pkg::DUR_W-1:0]        in_duration_us,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [irce_pkg::WORD_W-1:0]       out_pattern_word,
  output logic [irce_pkg::COUNT_W-1:0]      out_repeat_count,
  output logic                              out_is_space,
  output logic                              out_overflow
);
  import irce_pkg::*;

  logic [CARRIER_W-1:0] carrier_r, carrier_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic                 active_low_r, active_low_nxt;
  logic                 q_push, q_full, q_pop, q_empty;
  item_t                push_item, head_item;

  // Decode configuration writes
  always_comb begin
    carrier_nxt    = carrier_r;
    duty_nxt       = duty_r;
    active_low_nxt = active_low_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CARRIER_HZ: begin
          if (cfg_data != '0) begin
            carrier_nxt = cfg_data[CARRIER_W-1:0];
          end
        end
        CFG_DUTY_PERCENT: duty_nxt = cfg_data[DUTY_W-1:0];
        CFG_ACTIVE_LOW:   active_low_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r    <= CARRIER_W'(38000);
      duty_r       <= DUTY_W'(50);
      active_low_r <= 1'b0;
    end else begin
      carrier_r    <= carrier_nxt;
      duty_r       <= duty_nxt;
      active_low_r <= active_low_nxt;
    end
  end

  irce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_duration_us (in_duration_us),
    .in_frame_start (in_frame_start),
    .carrier_hz     (carrier_r),
    .duty_percent   (duty_r),
    .active_low     (active_low_r),
    .q_push         (q_push),
    .q_item         (push_item),
    .q_full         (q_full)
  );

  irce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  irce_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (head_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pattern_word (out_pattern_word),
    .out_repeat_count (out_repeat_count),
    .out_is_space     (out_is_space),
    .out_overflow     (out_overflow)
  );

endmodule

/* hw/rtl/irce_checker.sv */
// Checker: port-level assertions for the run encoder, bound to the top level.
module irce_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [irce_pkg::WORD_W-1:0]       out_pattern_word,
  input  logic [irce_pkg::COUNT_W-1:0]      out_repeat_count,
  input  logic                              out_is_space,
  input  logic                              out_overflow
);
  import irce_pkg::*;

  // Reset empties the pipeline and opens the input
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  // An overflowed frame reports no carrier periods
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_repeat_count == '0)
    else $error("repeat count nonzero on overflowed result");

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pattern_word) && $stable(out_repeat_count)
      && $stable(out_is_space) && $stable(out_overflow))
    else $error("result payload changed while stalled");

endmodule

bind ir_carrier_run_encoder irce_checker u_irce_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pattern_word (out_pattern_word),
  .out_repeat_count (out_repeat_count),
  .out_is_space     (out_is_space),
  .out_overflow     (out_overflow)
);

/* tb/irce_run_checker.sv */
// Checker: watches the request and result channels, predicts each run descriptor and compares.
module irce_run_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [irce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [irce_pkg::DUR_W-1:0]      in_duration_us,
  input  logic                            in_frame_start,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [irce_pkg::WORD_W-1:0]     out_pattern_word,
  input  logic [irce_pkg::COUNT_W-1:0]    out_repeat_count,
  input  logic                            out_is_space,
  input  logic                            out_overflow,
  output int                              fail_count,
  output int                              runs_pending
);
  import irce_pkg::*;

  localparam logic [CARRIER_W-1:0] CARRIER_RESET = CARRIER_W'(38000);
  localparam logic [DUTY_W-1:0]    DUTY_RESET    = DUTY_W'(50);
  localparam longint unsigned      US_PER_SEC    = 64'd1000000;
  localparam longint unsigned      HALF_SEC_US   = 64'd500000;

  typedef struct packed {
    logic [WORD_W-1:0]  pattern_word;
    logic [COUNT_W-1:0] repeat_count;
    logic               is_space;
    logic               overflow;
  } run_t;

  // Register copies
  logic [CARRIER_W-1:0] carrier_hz;
  logic [DUTY_W-1:0]    duty_percent;
  logic                 active_low;

  // Frame state
  longint unsigned words_used;
  logic            next_is_space;
  logic            frame_ovf;

  run_t runs_due[$];

  // Work out the run descriptor for one request and advance the frame state
  function automatic run_t predict_run(logic [DUR_W-1:0] dur, logic start);
    run_t            r;
    longint unsigned periods;
    logic [WORD_W-1:0] mark;
    if (start) begin
      words_used    = 0;
      next_is_space = 1'b0;
      frame_ovf     = 1'b0;
    end
    if (duty_percent >= DUTY_W'(90))      mark = WORD_DUTY_90;
    else if (duty_percent >= DUTY_W'(80)) mark = WORD_DUTY_80;
    else if (duty_percent >= DUTY_W'(75)) mark = WORD_DUTY_75;
    else if (duty_percent >= DUTY_W'(70)) mark = WORD_DUTY_70;
    else if (duty_percent >= DUTY_W'(60)) mark = WORD_DUTY_60;
    else                                  mark = WORD_DUTY_50;
    if (active_low) mark = ~mark;
    r.is_space = next_is_space;
    if (next_is_space) r.pattern_word = active_low ? WORD_SPACE_HI : WORD_SPACE_LO;
    else               r.pattern_word = mark;
    // full-width product, rounded half up
    periods = (64'(dur) * 64'(carrier_hz) + HALF_SEC_US) / US_PER_SEC;
    r.repeat_count = '0;
    if (!frame_ovf) begin
      if (words_used + periods >= longint'(BUFFER_WORDS)) begin
        frame_ovf = 1'b1;
      end else begin
        words_used     += periods;
        r.repeat_count = COUNT_W'(periods);
      end
    end
    r.overflow    = frame_ovf;
    next_is_space = ~r.is_space;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    runs_pending = 0;
  end

  // Track configuration, predict accepted requests, compare accepted results
  always @(posedge clk) begin : watch
    run_t want;
    if (!rst_n) begin
      carrier_hz    = CARRIER_RESET;
      duty_percent  = DUTY_RESET;
      active_low    = 1'b0;
      words_used    = 0;
      next_is_space = 1'b0;
      frame_ovf     = 1'b0;
      runs_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CARRIER_HZ: begin
            // drop a zero carrier, keep the old one
            if (cfg_data[CARRIER_W-1:0] != '0) carrier_hz = cfg_data[CARRIER_W-1:0];
          end
          CFG_DUTY_PERCENT: duty_percent = cfg_data[DUTY_W-1:0];
          CFG_ACTIVE_LOW:   active_low = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) runs_due.push_back(predict_run(in_duration_us, in_frame_start));
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          $display("%0t: run descriptor with none expected: word 0x%0h count %0d",
                   $time, out_pattern_word, out_repeat_count);
          fail_count++;
        end else begin
          want = runs_due.pop_front();
          check_field("pattern_word", want.pattern_word, out_pattern_word);
          check_field("repeat_count", want.repeat_count, out_repeat_count);
          check_field("is_space", want.is_space, out_is_space);
          check_field("overflow", want.overflow, out_overflow);
        end
      end
    end
    runs_pending = runs_due.size();
  end

endmodule

/* tb/testbench.sv */
// Testbench top: drives requests and configuration into the run encoder and gives the verdict.
module testbench;
  import irce_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 4;
  localparam int RANDOM_SEGMENTS = 6;
  localparam int SEGMENT_ITEMS   = 200;
  localparam int MAX_FRAME       = 40;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 16;
  localparam int CYCLE_LIMIT     = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [DUR_W-1:0]      in_duration_us;
  logic                  in_frame_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_W-1:0]     out_pattern_word;
  logic [COUNT_W-1:0]    out_repeat_count;
  logic                  out_is_space;
  logic                  out_overflow;

  int   fail_count;
  int   runs_pending;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  logic hold_req;
  logic hold_done;
  int   frame_left;
  int   cycle_cnt;

  ir_carrier_run_encoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_duration_us   (in_duration_us),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pattern_word (out_pattern_word),
    .out_repeat_count (out_repeat_count),
    .out_is_space     (out_is_space),
    .out_overflow     (out_overflow)
  );

  irce_run_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_duration_us   (in_duration_us),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pattern_word (out_pattern_word),
    .out_repeat_count (out_repeat_count),
    .out_is_space     (out_is_space),
    .out_overflow     (out_overflow),
    .fail_count       (fail_count),
    .runs_pending     (runs_pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Give up after the cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    int held;
    held      = 0;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_req && !hold_done) begin
        if (held < HOLD_CYCLES) begin
          out_stall <= 1'b1;
          held++;
        end else begin
          out_stall <= 1'b0;
          hold_done <= 1'b1;
        end
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random; return at the accepting edge
  task automatic send_request(input logic [DUR_W-1:0] dur, input logic fs);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_duration_us <= dur;
    in_frame_start <= fs;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic set_config(input logic [CARRIER_W-1:0] carrier,
                            input logic [DUTY_W-1:0] duty, input logic al);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_CARRIER_HZ;
    cfg_data  <= CFG_DATA_W'(carrier);
    @(posedge clk);
    cfg_index <= CFG_DUTY_PERCENT;
    cfg_data  <= CFG_DATA_W'(duty);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_data  <= CFG_DATA_W'(al);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold off the sender until every expected run has come back
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(negedge clk);
    while (runs_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Next request of a random frame: mostly short IR-like durations, some huge
  task automatic send_random_request();
    logic [DUR_W-1:0] dur;
    logic             fs;
    int               pick;
    pick = $urandom_range(99);
    if (frame_left == 0) begin
      frame_left = $urandom_range(1, MAX_FRAME);
      fs = 1'b1;
    end else begin
      // stray frame start in the middle of a frame
      fs = ($urandom_range(99) < 4);
    end
    frame_left--;
    if (pick < 70)      dur = DUR_W'($urandom_range(0, 3000));
    else if (pick < 90) dur = DUR_W'($urandom_range(0, 60000));
    else                dur = DUR_W'($urandom);
    send_request(dur, fs);
  endtask

  // Stimulus and verdict
  initial begin
    int seg;
    int duty_points[10];
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_CARRIER_HZ;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_duration_us = '0;
    in_frame_start = 1'b0;
    snd_idle_pct   = 0;
    rcv_idle_pct   = 0;
    hold_req       = 1'b0;
    frame_left     = 0;
    duty_points    = '{0, 59, 60, 69, 70, 74, 75, 79, 80, 89};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings; continue the frame without a frame start
    send_request(0, 1'b0);
    send_request(250, 1'b0);          // exact half period rounds up
    send_request(20'hFFFFF, 1'b1);    // overflows on its own
    send_request(1, 1'b0);            // overflow stays set
    send_request(100000, 1'b1);
    send_request(100000, 1'b0);
    send_request(20000, 1'b0);        // crosses the buffer size
    send_request(0, 1'b1);            // frame start clears overflow
    drain_requests();

    // Fastest carrier: product beyond 32 bits, buffer edge, active low
    set_config(500000, 100, 1'b1);
    send_request(16000, 1'b1);
    send_request(382, 1'b0);          // one word short of the buffer
    send_request(2, 1'b0);            // reaches the buffer exactly
    send_request(16384, 1'b1);
    send_request(1, 1'b1);
    drain_requests();

    // Zero carrier keeps the previous one; duty above range
    set_config(0, 101, 1'b0);
    send_request(3, 1'b1);

    // Sweep the duty thresholds
    for (int i = 0; i < 10; i++) begin
      drain_requests();
      set_config(38000, DUTY_W'(duty_points[i]), 1'(i));
      send_request(DUR_W'($urandom), 1'b1);
    end

    // Random frames under several settings and idling patterns
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      drain_requests();
      snd_idle_pct = seg < 2 ? 38 : seg < 4 ? 60 : 0;
      rcv_idle_pct <= seg < 2 ? 60 : seg < 4 ? 38 : 0;
      case (seg)
        0: set_config(38000, 65, 1'b1);
        1: set_config(500000, 127, 1'b0);
        2: set_config(1, 90, 1'b1);
        3: set_config(CARRIER_W'($urandom_range(1, 500000)), DUTY_W'($urandom_range(0, 100)),
                      1'($urandom_range(0, 1)));
        4: set_config(56000, 72, 1'b0);
        default: set_config(CARRIER_W'($urandom_range(1, 500000)), 77, 1'b1);
      endcase
      if (seg == 2) begin
        // keep offering while the receiver holds off, so the block backs up
        hold_req     <= 1'b1;
        snd_idle_pct = 0;
        while (!hold_done) send_random_request();
        snd_idle_pct = 60;
      end
      repeat (SEGMENT_ITEMS) send_random_request();
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
